/* rtl/core/assert_macros.svh */
// Assertion macros used by the receiver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define FPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("receiver assertion failed");
// expression must never be true outside reset
`define FPR_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("receiver forbidden condition seen");
`else
`define FPR_ASSERT(label, clk, rst, prop)
`define FPR_NEVER(label, clk, rst, expr)
`endif

`endif

/* rtl/core/fpr_pkg.sv */
// Types and constants of the framed packet receiver
package fpr_pkg;

   localparam int BYTE_W           = 8;
   localparam int FRAME_BYTES_DEF  = 64;
   localparam int HDR_BYTES        = 3;
   localparam int LEN_POS          = 2;
   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h02;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_DEST,
      ST_SRC,
      ST_LEN,
      ST_DATA,
      ST_CHECK,
      ST_REPLAY
   } state_type;

   typedef struct packed {
      logic clear;
      logic store;
      logic advance;
      logic load_len;
      logic rd_en;
   } cmd_type;

   typedef struct packed {
      logic start_hit;
      logic len_ok;
      logic data_end;
      logic sum_match;
      logic rd_last;
      logic slot_free;
   } status_type;

endpackage

/* rtl/core/fpr_req_if.sv */
// Receive byte channel
interface fpr_req_if import fpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/fpr_rsp_if.sv */
// Accepted frame byte channel
interface fpr_rsp_if import fpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* rtl/core/framed_packet_receiver_top.sv */
// Framed packet receiver top level
//
//  channel    dir  handshake     payload
//  req_chan   in   valid/ready   rx_byte
//  rsp_chan   out  valid/ready   frame_byte, last_byte
//  csr_*      in   wr_en         wr_data = start byte
//
// One received byte per cycle while parsing, set by the parser state machine.
// A frame with a good checksum is then replayed from the frame store at up to one
// byte per cycle unless rsp_chan stalls, len+3 bytes; req_chan.ready stays low.
// The replay rate is set by the single read port of the frame store.
// Reset is synchronous and needs no clearing pass; start byte resets to 2.
`include "assert_macros.svh"

module framed_packet_receiver_top import fpr_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   fpr_req_if.sink           req_chan,
   fpr_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpr_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .rx_byte     (req_chan.rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_chan.valid),
      .frame_byte  (rsp_chan.frame_byte),
      .last_byte   (rsp_chan.last_byte)
   );

   `FPR_ASSERT(a_read_fills_slot, clock, reset, cmd.rd_en |=> rsp_chan.valid)
   `FPR_NEVER(a_read_needs_slot, clock, reset, cmd.rd_en && !status.slot_free)
   `FPR_NEVER(a_no_rx_in_replay, clock, reset, req_chan.valid && req_chan.ready && cmd.rd_en)
   `FPR_NEVER(a_store_or_read, clock, reset, cmd.store && cmd.rd_en)

endmodule

/* rtl/core/fpr_ctrl.sv */
// Frame parser and replay sequencer state machine
module fpr_ctrl import fpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff != ST_REPLAY);
      accept    = req_valid && req_ready;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.start_hit) begin
               cmd.clear = 1'b1;
               state_in  = ST_DEST;
            end
         end
         ST_DEST: begin
            if (accept) begin
               cmd.store   = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_SRC;
            end
         end
         ST_SRC: begin
            if (accept) begin
               cmd.store   = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               if (status.len_ok) begin
                  cmd.store    = 1'b1;
                  cmd.advance  = 1'b1;
                  cmd.load_len = 1'b1;
                  state_in     = ST_DATA;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.store = 1'b1;
               if (status.data_end) begin
                  state_in = ST_CHECK;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               state_in = status.sum_match ? ST_REPLAY : ST_HUNT;
            end
         end
         ST_REPLAY: begin
            if (status.slot_free) begin
               cmd.rd_en = 1'b1;
               if (status.rd_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

endmodule

/* rtl/core/fpr_datapath.sv */
// Frame store, checksum, position counters and output register
module fpr_datapath import fpr_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data,
   input  logic              rsp_ready,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] frame_byte,
   output logic              last_byte
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [BYTE_W-1:0] LEN_LIMIT = BYTE_W'(FRAME_BYTES - HDR_BYTES);

   logic [BYTE_W-1:0] mem [FRAME_BYTES];

   logic [BYTE_W-1:0] start_ff;
   logic [POS_W-1:0]  pos_ff,    pos_in;
   logic [BYTE_W-1:0] sum_ff,    sum_in;
   logic [POS_W-1:0]  len_ff;
   logic [POS_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              valid_ff,  valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;
   logic [POS_W-1:0]  end_pos;

   assign end_pos = len_ff + POS_W'(LEN_POS);

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      rd_ptr_in = rd_ptr_ff;
      if (cmd.clear) begin
         pos_in    = '0;
         sum_in    = '0;
         rd_ptr_in = '0;
      end
      if (cmd.store) begin
         sum_in = sum_ff + rx_byte;
      end
      if (cmd.advance) begin
         pos_in = pos_ff + POS_W'(1);
      end
      if (cmd.rd_en) begin
         rd_ptr_in = rd_ptr_ff + POS_W'(1);
      end
      valid_in = cmd.rd_en ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_BYTE_RESET;
         pos_ff    <= '0;
         sum_ff    <= '0;
         rd_ptr_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         rd_ptr_ff <= rd_ptr_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_len) begin
         len_ff <= rx_byte[POS_W-1:0];
      end
      if (cmd.rd_en) begin
         last_ff <= status.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[pos_ff] <= rx_byte;
      end
      if (cmd.rd_en) begin
         data_ff <= mem[rd_ptr_ff];
      end
   end

   always_comb begin
      status.start_hit = (rx_byte == start_ff);
      status.len_ok    = (rx_byte != '0) && (rx_byte < LEN_LIMIT);
      status.data_end  = (pos_ff == end_pos);
      status.sum_match = (sum_ff == rx_byte);
      status.rd_last   = (rd_ptr_ff == end_pos);
      status.slot_free = !valid_ff || rsp_ready;
   end

   assign rsp_valid  = valid_ff;
   assign frame_byte = data_ff;
   assign last_byte  = last_ff;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the framed packet receiver: frame parsing, checksum and replay
module testbench;
   import fpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_LEN       = FRAME_BYTES_DEF - HDR_BYTES - 1;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
   } frame_beat_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   fpr_req_if req_bus ();
   fpr_rsp_if rsp_bus ();

   framed_packet_receiver_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // frame parser prediction state
   state_type         rx_phase;
   logic [5:0]        rx_pos;
   logic [BYTE_W-1:0] rx_sum;
   logic [BYTE_W-1:0] body_mem [FRAME_BYTES_DEF];
   logic [BYTE_W-1:0] cfg_start;

   frame_beat_type    frame_exp [$];
   frame_beat_type    beat;
   logic [BYTE_W-1:0] rx_pending [$];
   logic [BYTE_W-1:0] frame_start;

   logic req_took;
   bit   calm;
   int   bytes_queued;
   int   bytes_taken;
   int   bytes_replayed;
   int   frames_sent;
   int   frames_replayed;
   int   mismatch_count;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic void store_body(input logic [BYTE_W-1:0] c);
      body_mem[rx_pos] = c;
      rx_sum = rx_sum + c;
   endfunction

   function automatic void parse_rx_byte(input logic [BYTE_W-1:0] c);
      int total;
      frame_beat_type b;
      case (rx_phase)
         ST_HUNT: begin
            if (c == cfg_start) begin
               rx_pos   = '0;
               rx_sum   = '0;
               rx_phase = ST_DEST;
            end
         end
         ST_DEST: begin
            store_body(c);
            rx_pos   = rx_pos + 6'd1;
            rx_phase = ST_SRC;
         end
         ST_SRC: begin
            store_body(c);
            rx_pos   = rx_pos + 6'd1;
            rx_phase = ST_LEN;
         end
         ST_LEN: begin
            if (c != 0 && c < FRAME_BYTES_DEF - HDR_BYTES) begin
               store_body(c);
               rx_pos   = rx_pos + 6'd1;
               rx_phase = ST_DATA;
            end else begin
               rx_phase = ST_HUNT;
            end
         end
         ST_DATA: begin
            store_body(c);
            if (int'(rx_pos) == int'(body_mem[LEN_POS]) + 2) begin
               rx_phase = ST_CHECK;
            end else begin
               rx_pos = rx_pos + 6'd1;
            end
         end
         ST_CHECK: begin
            if (rx_sum == c) begin
               total = int'(body_mem[LEN_POS]) + HDR_BYTES;
               if (total > FRAME_BYTES_DEF - 1) total = FRAME_BYTES_DEF - 1;
               for (int k = 0; k < total; k++) begin
                  b.frame_byte = body_mem[6'(k)];
                  b.last_byte  = (k + 1 == total);
                  frame_exp.push_back(b);
               end
            end
            rx_phase = ST_HUNT;
         end
         default: rx_phase = ST_HUNT;
      endcase
   endfunction

   // predict on accepted bytes, check replayed bytes
   always @(posedge clock) begin
      req_took <= !reset && req_bus.valid && req_bus.ready;
      if (reset) begin
         rx_phase  = ST_HUNT;
         rx_pos    = '0;
         rx_sum    = '0;
         cfg_start = START_BYTE_RESET;
         frame_exp.delete();
      end else begin
         if (csr_wr_en) cfg_start = csr_wr_data;
         if (req_bus.valid && req_bus.ready) begin
            parse_rx_byte(req_bus.rx_byte);
            bytes_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frame_exp.size() == 0) begin
               $display("%0t: unexpected transfer, frame_byte %02h last_byte %0b", $time,
                        rsp_bus.frame_byte, rsp_bus.last_byte);
               mismatch_count++;
            end else begin
               beat = frame_exp.pop_front();
               if (rsp_bus.frame_byte !== beat.frame_byte) begin
                  $display("%0t: frame_byte expected %02h actual %02h", $time,
                           beat.frame_byte, rsp_bus.frame_byte);
                  mismatch_count++;
               end
               if (rsp_bus.last_byte !== beat.last_byte) begin
                  $display("%0t: last_byte expected %0b actual %0b", $time,
                           beat.last_byte, rsp_bus.last_byte);
                  mismatch_count++;
               end
            end
            bytes_replayed++;
            if (rsp_bus.last_byte) frames_replayed++;
         end
      end
   end

   // drive bytes and response backpressure on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 31);
         if (!req_bus.valid || req_took) begin
            if (rx_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= rx_pending.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      rx_pending.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input logic [BYTE_W-1:0] dest, input logic [BYTE_W-1:0] src,
                              input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] fill,
                              input bit rand_fill, input bit corrupt);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      frames_sent++;
      push_byte(frame_start);
      push_byte(dest);
      push_byte(src);
      push_byte(len);
      if (len == 0 || len >= FRAME_BYTES_DEF - HDR_BYTES) return;
      sum = dest + src + len;
      for (int i = 0; i < len; i++) begin
         b = rand_fill ? BYTE_W'($urandom) : fill;
         push_byte(b);
         sum = sum + b;
      end
      if (corrupt) sum = sum + BYTE_W'($urandom_range(1, 255));
      push_byte(sum);
   endtask

   task automatic queue_random(input int target);
      int n;
      int kind;
      logic [BYTE_W-1:0] len;
      n = 0;
      while (n < target) begin
         kind = $urandom_range(0, 99);
         len  = ($urandom_range(0, 19) == 0) ? BYTE_W'($urandom_range(9, MAX_LEN))
                                             : BYTE_W'($urandom_range(1, 8));
         if (kind < 80) begin
            queue_frame(BYTE_W'($urandom), BYTE_W'($urandom), len, '0, 1'b1, kind >= 70);
            n += len + 5;
         end else if (kind < 90) begin
            len = $urandom_range(0, 1) ? BYTE_W'(0)
                                       : BYTE_W'($urandom_range(MAX_LEN + 1, 255));
            queue_frame(BYTE_W'($urandom), BYTE_W'($urandom), len, '0, 1'b1, 1'b0);
            n += 4;
         end else begin
            repeat ($urandom_range(1, 5)) push_byte(BYTE_W'($urandom));
         end
      end
   endtask

   task automatic wait_drain();
      while (bytes_taken != bytes_queued || frame_exp.size() != 0) @(negedge clock);
   endtask

   task automatic write_start(input logic [BYTE_W-1:0] value);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      frame_start = value;
   endtask

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      calm            = 1'b0;
      frame_start     = START_BYTE_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, bad length both ways, bad checksum, start byte as content
      @(negedge clock);
      queue_frame(8'hFF, 8'h00, 8'd1, 8'hFF, 1'b0, 1'b0);
      queue_frame(8'h00, 8'hFF, 8'd0, 8'h00, 1'b0, 1'b0);
      queue_frame(8'hA5, 8'h5A, BYTE_W'(MAX_LEN + 1), 8'h00, 1'b0, 1'b0);
      queue_frame(8'h12, 8'h34, 8'd1, 8'h80, 1'b0, 1'b1);
      queue_frame(START_BYTE_RESET, START_BYTE_RESET, 8'd2, START_BYTE_RESET, 1'b0, 1'b0);
      wait_drain();

      write_start(8'hFF);
      queue_frame(8'h01, 8'hFE, BYTE_W'(MAX_LEN), 8'h00, 1'b1, 1'b0);
      queue_random(32);
      wait_drain();

      // hold off idling for a long stretch
      write_start(8'h00);
      calm = 1'b1;
      queue_random(32);
      wait_drain();
      calm = 1'b0;

      write_start(BYTE_W'($urandom));
      queue_random(32);
      wait_drain();

      write_start(8'h7E);
      queue_random(16);
      wait_drain();
      queue_random(16);
      wait_drain();

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d frames in %0d bytes; %0d frames replayed as %0d transfers",
               frames_sent, bytes_taken, frames_replayed, bytes_replayed);
      $display("Start byte settings: reset value, 0xFF, 0x00, random, 0x7E");
      if (mismatch_count == 0 && frame_exp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/fpr_pkg.sv
rtl/core/fpr_req_if.sv
rtl/core/fpr_rsp_if.sv
rtl/core/fpr_ctrl.sv
rtl/core/fpr_datapath.sv
rtl/core/framed_packet_receiver_top.sv
dv/testbench.sv
